/* rtl/nms_pkg.sv */
// nms_pkg: shared types, constants and register codes of the 3x3 non-maximum suppression block
// no dependencies; used by every other rtl file
`default_nettype none

package nms_pkg;

    localparam int NMS_MAX_WIDTH = 1024;

    localparam int FW_W     = 11;
    localparam int FH_W     = 13;
    localparam int CFG_DW   = 13;
    localparam int PIX_W    = 8;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;

    localparam logic [PIX_W-1:0] MARK_ON  = 8'd255;
    localparam logic [PIX_W-1:0] MARK_OFF = 8'd0;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    // one window step travelling from the counter stage to the compare stage
    typedef struct packed {
        logic             valid;
        logic             restart;
        logic             emit;
        logic             top;
        logic             bot;
        logic             lft;
        logic             rgt;
        logic [PIX_W-1:0] value;
    } step_t;

endpackage

`default_nettype wire

/* rtl/nms_if.sv */
// nms_in_if / nms_out_if: valid-ready channels for pixel beats and result beats
// depends on nms_pkg for field widths
`default_nettype none

interface nms_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [nms_pkg::PIX_W-1:0]   pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

interface nms_out_if;
    logic                        valid;
    logic                        ready;
    logic [nms_pkg::PIX_W-1:0]   mark;
    logic                        frame_end;

    modport source (output valid, output mark, output frame_end, input ready);
    modport sink   (input valid, input mark, input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/edge_nonmax_suppression_3x3.sv */
// edge_nonmax_suppression_3x3: streaming 3x3 non-maximum suppression over 8-bit edge pixels
// throughput: one beat per cycle while the queue has room and no extra step is owed
// line store read-modify-write is pipelined; results are registered as a step, then queued
// single-row frames: the first flush beat is a silent window step; one extra step follows
// reset: counters, window and queue clear at once; line stores need no clearing pass
// depends on nms_pkg, nms_if, nms_front, nms_line_store, nms_window, nms_out_fifo
`default_nettype none

module edge_nonmax_suppression_3x3 #(
    parameter int MAX_WIDTH = nms_pkg::NMS_MAX_WIDTH
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [nms_pkg::CFG_DW-1:0]  cfg_data,
    nms_in_if.sink                           pixels,
    nms_out_if.source                        results
);

    localparam int AW = $clog2(MAX_WIDTH);

    logic                      room, full, rd_en, extra_pending, push, frame_end;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic [nms_pkg::PIX_W-1:0] above, center, mark;
    nms_pkg::step_t            step;

    nms_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixels      (pixels),
        .room        (room),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .wr_addr_reg (wr_addr),
        .step_reg    (step),
        .extra_reg   (extra_pending)
    );

    nms_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_en    (step.valid),
        .wr_addr  (wr_addr),
        .wr_value (step.value),
        .above    (above),
        .center   (center)
    );

    nms_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (cfg_we),
        .step      (step),
        .above     (above),
        .center    (center),
        .push      (push),
        .mark      (mark),
        .frame_end (frame_end)
    );

    nms_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .mark      (mark),
        .frame_end (frame_end),
        .pending   (step.valid),
        .room      (room),
        .full      (full),
        .results   (results)
    );

    // the result queue never takes a beat it has no slot for
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result queue overflow");

    // no new pixel beat while the extra flush step is still owed
    a_extra_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        extra_pending |-> !pixels.ready)
        else $error("input taken during extra flush step");

    // a step is only launched when the queue has reserved room for it
    a_step_reserved: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> room)
        else $error("window step launched without queue room");

    a_mark_code: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.mark == nms_pkg::MARK_ON || results.mark == nms_pkg::MARK_OFF))
        else $error("mark code out of range");

endmodule

`default_nettype wire

/* rtl/nms_front.sv */
// nms_front: configuration registers, raster counters, flush handling and line store addressing
// depends on nms_pkg and nms_in_if
`default_nettype none

module nms_front #(
    parameter int MAX_WIDTH = nms_pkg::NMS_MAX_WIDTH,
    localparam int AW  = $clog2(MAX_WIDTH),
    localparam int CW1 = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [nms_pkg::CFG_DW-1:0]  cfg_data,
    nms_in_if.sink                           pixels,
    input  wire logic                        room,
    output logic                             rd_en,
    output logic [AW-1:0]                    rd_addr,
    output logic [AW-1:0]                    wr_addr_reg,
    output nms_pkg::step_t                   step_reg,
    output logic                             extra_reg
);

    localparam int WW  = (CW1 > nms_pkg::FW_W) ? CW1 : nms_pkg::FW_W;
    localparam int IRW = nms_pkg::FH_W + 1;
    localparam int ORW = nms_pkg::FH_W;

    logic [nms_pkg::FW_W-1:0] frame_width_reg;
    logic [nms_pkg::FH_W-1:0] frame_height_reg;
    logic [IRW-1:0]           in_row_reg, in_row_next;
    logic [AW-1:0]            in_col_reg, in_col_next;
    logic [ORW-1:0]           out_row_reg, out_row_next;
    logic [AW-1:0]            out_col_reg, out_col_next;
    logic                     extra_next;
    nms_pkg::step_t           step_next;

    logic [WW-1:0]            fw_ext;
    logic [CW1-1:0]           eff_w;
    logic [nms_pkg::FH_W-1:0] eff_h;
    logic                     accept, is_pix, flush_ok, issue_in, issue_extra, issue;
    logic                     rst_step, due;
    logic [IRW-1:0]           ir;
    logic [AW-1:0]            ic;
    logic [ORW-1:0]           orow;
    logic [AW-1:0]            oc;

    always_comb
    begin
        fw_ext = WW'(frame_width_reg);
        if (fw_ext == '0)
        begin
            eff_w = CW1'(1);
        end
        else if (fw_ext > WW'(MAX_WIDTH))
        begin
            eff_w = CW1'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CW1'(fw_ext);
        end
        eff_h = (frame_height_reg == '0) ? nms_pkg::FH_W'(1) : frame_height_reg;
    end

    assign pixels.ready = !extra_reg && room;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        case (pixels.opcode)
            nms_pkg::OP_PIXEL: is_pix = 1'b1;
            nms_pkg::OP_FLUSH: is_pix = 1'b0;
            default:           is_pix = 1'b0;
        endcase
    end

    // a flush only counts once the frame is in and results are still owed
    assign flush_ok    = (in_row_reg >= IRW'(eff_h)) && (out_row_reg < eff_h);
    assign issue_in    = accept && (is_pix || flush_ok);
    assign issue_extra = extra_reg && room;
    assign issue       = issue_in || issue_extra;
    assign rst_step    = issue_in && is_pix && (in_row_reg >= IRW'(eff_h));

    always_comb
    begin
        ir   = rst_step ? '0 : in_row_reg;
        ic   = rst_step ? '0 : in_col_reg;
        orow = rst_step ? '0 : out_row_reg;
        oc   = rst_step ? '0 : out_col_reg;

        due = (ir >= IRW'(2)) || ((ir == IRW'(1)) && (ic != '0));

        step_next.valid   = issue;
        step_next.restart = rst_step;
        step_next.emit    = due;
        step_next.top     = (orow == '0);
        step_next.bot     = ((IRW'(orow) + IRW'(1)) >= IRW'(eff_h));
        step_next.lft     = (oc == '0);
        step_next.rgt     = ((CW1'(oc) + CW1'(1)) >= eff_w);
        step_next.value   = (issue_in && is_pix) ? pixels.pixel_value : '0;

        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (issue)
        begin
            if ((CW1'(ic) + CW1'(1)) >= eff_w)
            begin
                in_col_next = '0;
                in_row_next = ir + IRW'(1);
            end
            else
            begin
                in_col_next = ic + AW'(1);
                in_row_next = ir;
            end
            out_row_next = orow;
            out_col_next = oc;
            if (due)
            begin
                if ((CW1'(oc) + CW1'(1)) >= eff_w)
                begin
                    out_col_next = '0;
                    out_row_next = orow + ORW'(1);
                end
                else
                begin
                    out_col_next = oc + AW'(1);
                end
            end
        end

        // single-row frame: first flush step is silent, a second step follows
        extra_next = extra_reg;
        if (issue_in && !is_pix && !due)
        begin
            extra_next = 1'b1;
        end
        else if (issue_extra)
        begin
            extra_next = 1'b0;
        end
    end

    assign rd_en   = issue;
    assign rd_addr = ic;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= nms_pkg::FW_RESET;
            frame_height_reg <= nms_pkg::FH_RESET;
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
            extra_reg        <= 1'b0;
            step_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                nms_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[nms_pkg::FW_W-1:0];
                nms_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[nms_pkg::FH_W-1:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            extra_reg   <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            extra_reg   <= extra_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            wr_addr_reg <= ic;
        end
    end

endmodule

`default_nettype wire

/* rtl/nms_line_store.sv */
// nms_line_store: the two row memories, read in the cycle before the write-back, which goes in place
// depends on nms_pkg; forwards the write-back when the next read hits the same column
`default_nettype none

module nms_line_store #(
    parameter int MAX_WIDTH = nms_pkg::NMS_MAX_WIDTH,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       rd_en,
    input  wire logic [AW-1:0]              rd_addr,
    input  wire logic                       wr_en,
    input  wire logic [AW-1:0]              wr_addr,
    input  wire logic [nms_pkg::PIX_W-1:0]  wr_value,
    output logic [nms_pkg::PIX_W-1:0]       above,
    output logic [nms_pkg::PIX_W-1:0]       center
);

    logic [nms_pkg::PIX_W-1:0] above_mem  [MAX_WIDTH];
    logic [nms_pkg::PIX_W-1:0] center_mem [MAX_WIDTH];
    logic [nms_pkg::PIX_W-1:0] above_q, center_q;
    logic [nms_pkg::PIX_W-1:0] fwd_above_reg, fwd_center_reg;
    logic                      fwd_reg;

    assign above  = fwd_reg ? fwd_above_reg  : above_q;
    assign center = fwd_reg ? fwd_center_reg : center_q;

    // row shift: centre row moves up, the new pixel becomes the centre row
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            above_mem[wr_addr]  <= center;
            center_mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            above_q  <= above_mem[rd_addr];
            center_q <= center_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_above_reg  <= center;
        fwd_center_reg <= wr_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= rd_en && wr_en && (rd_addr == wr_addr);
        end
    end

endmodule

`default_nettype wire

/* rtl/nms_window.sv */
// nms_window: 3x3 window registers and the four-direction local maximum test
// depends on nms_pkg (step_t, mark codes)
`default_nettype none

module nms_window (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       clear,
    input  wire nms_pkg::step_t             step,
    input  wire logic [nms_pkg::PIX_W-1:0]  above,
    input  wire logic [nms_pkg::PIX_W-1:0]  center,
    output logic                            push,
    output logic [nms_pkg::PIX_W-1:0]       mark,
    output logic                            frame_end
);

    logic [nms_pkg::PIX_W-1:0] win_reg [3][3];
    logic [nms_pkg::PIX_W-1:0] old     [3][3];
    logic [nms_pkg::PIX_W-1:0] c, ul, dr, ur, dl, up, dn, lf, rt;
    logic                      on;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                old[r][k] = step.restart ? '0 : win_reg[r][k];
            end
        end
    end

    // neighbours taken from the window as it stands after this shift
    always_comb
    begin
        c  = old[1][2];
        ul = (step.top || step.lft) ? '0 : old[0][1];
        dr = (step.bot || step.rgt) ? '0 : step.value;
        ur = (step.top || step.rgt) ? '0 : above;
        dl = (step.bot || step.lft) ? '0 : old[2][1];
        up = step.top ? '0 : old[0][2];
        dn = step.bot ? '0 : old[2][2];
        lf = step.lft ? '0 : old[1][1];
        rt = step.rgt ? '0 : center;
        on = ((ul < c) && (dr < c)) || ((ur < c) && (dl < c)) ||
             ((up < c) && (dn < c)) || ((lf < c) && (rt < c));
    end

    assign push      = step.valid && step.emit;
    assign mark      = on ? nms_pkg::MARK_ON : nms_pkg::MARK_OFF;
    assign frame_end = step.bot && step.rgt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (clear)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (step.valid)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= old[r][1];
                win_reg[r][1] <= old[r][2];
            end
            win_reg[0][2] <= above;
            win_reg[1][2] <= center;
            win_reg[2][2] <= step.value;
        end
    end

endmodule

`default_nettype wire

/* rtl/nms_out_fifo.sv */
// nms_out_fifo: three-entry result queue driving the result channel
// depends on nms_pkg and nms_out_if; room accounts for a step still in flight
`default_nettype none

module nms_out_fifo (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [nms_pkg::PIX_W-1:0]  mark,
    input  wire logic                       frame_end,
    input  wire logic                       pending,
    output logic                            room,
    output logic                            full,
    nms_out_if.source                       results
);

    localparam int DEPTH = 3;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    logic [nms_pkg::PIX_W-1:0] mark_reg [DEPTH];
    logic                      end_reg  [DEPTH];
    logic [PW-1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0]           count_reg, count_next;
    logic                      pop;

    assign results.valid     = (count_reg != '0);
    assign results.mark      = mark_reg[rd_ptr_reg];
    assign results.frame_end = end_reg[rd_ptr_reg];
    assign pop               = results.valid && results.ready;
    assign full              = (count_reg == CNTW'(DEPTH));
    assign room              = ((CNTW + 1)'(count_reg) + (CNTW + 1)'(pending))
                               < (CNTW + 1)'(DEPTH);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mark_reg[wr_ptr_reg] <= mark;
            end_reg[wr_ptr_reg]  <= frame_end;
        end
    end

endmodule

`default_nettype wire
